[rtl/jcmd_pkg.sv]
`timescale 1ns / 1ps

package jcmd_pkg;

  localparam int SAMPLE_W = 10;
  localparam int DELAY_W = 10;
  localparam int STEP_W = 8;
  localparam int WAIT_W = 11;
  localparam int POS_W = 3;
  localparam int LINE_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;
  localparam int GRID_SIZE = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FAST_LOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_LOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_DELAY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_DELAY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_STEP = 3'd6;

  localparam logic [SAMPLE_W-1:0] RST_FAST_LOW = 10'd250;
  localparam logic [SAMPLE_W-1:0] RST_SLOW_LOW = 10'd500;
  localparam logic [SAMPLE_W-1:0] RST_SLOW_HIGH = 10'd550;
  localparam logic [SAMPLE_W-1:0] RST_FAST_HIGH = 10'd787;
  localparam logic [DELAY_W-1:0] RST_SLOW_DELAY = 10'd400;
  localparam logic [DELAY_W-1:0] RST_FAST_DELAY = 10'd200;
  localparam logic [STEP_W-1:0] RST_DELAY_STEP = 8'd20;
  localparam logic [LINE_W-1:0] ROWS_OFF = 8'hFF;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_POS = 2'd1;
  localparam logic [1:0] DIR_NEG = 2'd2;

  typedef struct packed {
    logic [1:0] dir;
    logic [DELAY_W-1:0] delay;
  } cmd_t;

  typedef struct packed {
    logic [LINE_W-1:0] row_drive;
    logic [LINE_W-1:0] column_drive;
    logic next_channel;
    logic [POS_W-1:0] cursor_x;
    logic [POS_W-1:0] cursor_y;
  } res_t;

  function automatic logic [POS_W-1:0] inc_wrap(input logic [POS_W-1:0] p);
    logic [POS_W:0] n;
    n = {1'b0, p} + 1'b1;
    return (n >= (POS_W+1)'(GRID_SIZE)) ? '0 : n[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] dec_wrap(input logic [POS_W-1:0] p);
    return (p == '0) ? POS_W'(GRID_SIZE - 1) : p - 1'b1;
  endfunction

endpackage

[rtl/joystick_cursor_matrix_driver.sv]
// Joystick cursor driver for an 8x8 LED matrix. Each item pushed is one 10-bit
// joystick sample, alternately for the X and the Y axis (X first after reset);
// each item yields exactly one result carrying the row and column drive latches,
// the axis of the next sample and both cursor positions. The block takes one
// item per clock cycle while in_full is low; each result passes through the
// command queue, after classification, and then the result queue, after the
// cursor update, before it can be popped. Full rises only when results are not
// popped and both queues have filled. Configuration writes are always ready
// and must be made while no item is in flight.
`timescale 1ns / 1ps

module joystick_cursor_matrix_driver
  import jcmd_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [SAMPLE_W-1:0]   in_adc_sample,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [LINE_W-1:0]     out_row_drive,
  output logic [LINE_W-1:0]     out_column_drive,
  output logic                  out_next_channel,
  output logic [POS_W-1:0]      out_cursor_x,
  output logic [POS_W-1:0]      out_cursor_y,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd_in, cmd_head;
  res_t res_in, res_head;
  logic [STEP_W-1:0] delay_step;
  logic cmd_empty, cmd_pop, res_full, res_push;

  jcmd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample     (in_adc_sample),
    .cmd        (cmd_in),
    .delay_step (delay_step)
  );

  jcmd_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH_P)
  ) u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );

  jcmd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_empty  (cmd_empty),
    .cmd        (cmd_head),
    .cmd_pop    (cmd_pop),
    .delay_step (delay_step),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in)
  );

  jcmd_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH_P)
  ) u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_head),
    .empty (out_empty)
  );

  assign out_row_drive = res_head.row_drive;
  assign out_column_drive = res_head.column_drive;
  assign out_next_channel = res_head.next_channel;
  assign out_cursor_x = res_head.cursor_x;
  assign out_cursor_y = res_head.cursor_y;

endmodule

[rtl/jcmd_queue.sv]
`timescale 1ns / 1ps

module jcmd_queue
  import jcmd_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/jcmd_front.sv]
`timescale 1ns / 1ps

module jcmd_front
  import jcmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [SAMPLE_W-1:0]   sample,
  output cmd_t                  cmd,
  output logic [STEP_W-1:0]     delay_step
);

  logic [SAMPLE_W-1:0] fast_low_r, slow_low_r, slow_high_r, fast_high_r;
  logic [DELAY_W-1:0] slow_delay_r, fast_delay_r;
  logic [STEP_W-1:0] delay_step_r;

  assign cfg_ready = 1'b1;
  assign delay_step = delay_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_low_r <= RST_FAST_LOW;
      slow_low_r <= RST_SLOW_LOW;
      slow_high_r <= RST_SLOW_HIGH;
      fast_high_r <= RST_FAST_HIGH;
      slow_delay_r <= RST_SLOW_DELAY;
      fast_delay_r <= RST_FAST_DELAY;
      delay_step_r <= RST_DELAY_STEP;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FAST_LOW: fast_low_r <= cfg_data;
        REG_SLOW_LOW: slow_low_r <= cfg_data;
        REG_SLOW_HIGH: slow_high_r <= cfg_data;
        REG_FAST_HIGH: fast_high_r <= cfg_data;
        REG_SLOW_DELAY: slow_delay_r <= cfg_data;
        REG_FAST_DELAY: fast_delay_r <= cfg_data;
        REG_DELAY_STEP: delay_step_r <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sample > slow_high_r && sample < fast_high_r) begin
      cmd.dir = DIR_POS;
      cmd.delay = slow_delay_r;
    end else if (sample > fast_high_r) begin
      cmd.dir = DIR_POS;
      cmd.delay = fast_delay_r;
    end else if (sample < slow_low_r && sample > fast_low_r) begin
      cmd.dir = DIR_NEG;
      cmd.delay = slow_delay_r;
    end else if (sample < fast_low_r) begin
      cmd.dir = DIR_NEG;
      cmd.delay = fast_delay_r;
    end else begin
      cmd.dir = DIR_STOP;
      cmd.delay = '0;
    end
  end

endmodule

[rtl/jcmd_back.sv]
`timescale 1ns / 1ps

module jcmd_back
  import jcmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_empty,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  input  logic [STEP_W-1:0] delay_step,
  input  logic              res_full,
  output logic              res_push,
  output res_t              res
);

  logic phase_r, phase_nxt;
  logic [POS_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [WAIT_W-1:0] x_wait_r, x_wait_nxt, y_wait_r, y_wait_nxt;
  logic [LINE_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [WAIT_W-1:0] wait_cur, wait_adv;
  logic reach;

  assign cmd_pop = !cmd_empty && !res_full;
  assign res_push = cmd_pop;

  assign wait_cur = phase_r ? y_wait_r : x_wait_r;
  assign reach = !(wait_cur < WAIT_W'(cmd.delay) && cmd.delay != '0);
  assign wait_adv = reach ? '0 : wait_cur + WAIT_W'(delay_step);

  always_comb begin
    phase_nxt = ~phase_r;
    x_nxt = x_r;
    y_nxt = y_r;
    x_wait_nxt = x_wait_r;
    y_wait_nxt = y_wait_r;
    row_nxt = row_r;
    col_nxt = col_r;
    if (!phase_r) begin
      x_wait_nxt = wait_adv;
      if (reach && cmd.dir == DIR_POS) begin
        x_nxt = inc_wrap(x_r);
      end else if (reach && cmd.dir == DIR_NEG) begin
        x_nxt = dec_wrap(x_r);
      end
    end else begin
      y_wait_nxt = wait_adv;
      if (reach && cmd.dir == DIR_POS) begin
        y_nxt = dec_wrap(y_r);
      end else if (reach && cmd.dir == DIR_NEG) begin
        y_nxt = inc_wrap(y_r);
      end
      if (reach) begin
        row_nxt = ~(LINE_W'(1) << y_nxt);
        col_nxt = LINE_W'(1) << x_r;
      end
    end
  end

  always_comb begin
    res.row_drive = row_nxt;
    res.column_drive = col_nxt;
    res.next_channel = phase_nxt;
    res.cursor_x = x_nxt;
    res.cursor_y = y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      x_r <= '0;
      y_r <= '0;
      x_wait_r <= '0;
      y_wait_r <= '0;
      row_r <= ROWS_OFF;
      col_r <= '0;
    end else if (cmd_pop) begin
      phase_r <= phase_nxt;
      x_r <= x_nxt;
      y_r <= y_nxt;
      x_wait_r <= x_wait_nxt;
      y_wait_r <= y_wait_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

[rtl/jcmd_checker.sv]
`timescale 1ns / 1ps

module jcmd_checker
  import jcmd_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_empty,
  input logic                out_pop,
  input logic [LINE_W-1:0]   out_row_drive,
  input logic [LINE_W-1:0]   out_column_drive,
  input logic                out_next_channel
);

  logic exp_channel_r;

  // The first result points at the Y axis, and each later one flips.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_channel_r <= 1'b1;
    end else if (out_pop && !out_empty) begin
      exp_channel_r <= ~exp_channel_r;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_channel_alternates: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_next_channel == exp_channel_r)
    else $error("next channel does not alternate between items");

  a_latches_paired: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_row_drive == ROWS_OFF && out_column_drive == '0) ||
      ($countones(~out_row_drive) == 1 && $onehot(out_column_drive)))
    else $error("row and column drive are not a consistent pair");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_row_drive) &&
      $stable(out_column_drive) && $stable(out_next_channel))
    else $error("stalled result changed");

endmodule

bind joystick_cursor_matrix_driver jcmd_checker u_jcmd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_row_drive    (out_row_drive),
  .out_column_drive (out_column_drive),
  .out_next_channel (out_next_channel)
);

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import jcmd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  typed;
    res_t                  want;
  } row_t;

  localparam row_t DIRECTED [25] = '{
    '{1'b0, REG_FAST_LOW, 10'd525, 1'b1, '{8'hFF, 8'h00, 1'b1, 3'd0, 3'd0}},
    '{1'b0, REG_FAST_LOW, 10'd525, 1'b1, '{8'hFE, 8'h01, 1'b0, 3'd0, 3'd0}},
    '{1'b0, REG_FAST_LOW, 10'd0,    1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd1023, 1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd250,  1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd500,  1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd550,  1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd787,  1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd251,  1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd499,  1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd551,  1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd786,  1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd788,  1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd249,  1'b0, '0},
    '{1'b1, REG_SLOW_DELAY, 10'd0,  1'b0, '0},
    '{1'b1, REG_FAST_DELAY, 10'd0,  1'b0, '0},
    '{1'b1, REG_UNUSED, 10'h3FF,    1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd1023, 1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd1023, 1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd0,    1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd0,    1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd0,    1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd600,  1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd1023, 1'b0, '0},
    '{1'b0, REG_FAST_LOW, 10'd525,  1'b0, '0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic [SAMPLE_W-1:0]   in_adc_sample;
  logic                  out_empty;
  logic                  out_pop;
  logic [LINE_W-1:0]     out_row_drive;
  logic [LINE_W-1:0]     out_column_drive;
  logic                  out_next_channel;
  logic [POS_W-1:0]      out_cursor_x;
  logic [POS_W-1:0]      out_cursor_y;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  joystick_cursor_matrix_driver dut (.*);

  // Shadow copy of the registers and the cursor state.
  logic [SAMPLE_W-1:0] thr_fast_low, thr_slow_low, thr_slow_high, thr_fast_high;
  logic [DELAY_W-1:0]  dly_slow, dly_fast;
  logic [STEP_W-1:0]   wait_step;
  logic                axis_y;
  logic [POS_W-1:0]    pos_x, pos_y;
  logic [WAIT_W-1:0]   wait_x, wait_y;
  logic [LINE_W-1:0]   row_latch_q, col_latch_q;

  res_t pending_frames [$];
  bit   typed_now;
  res_t typed_want;
  int   send_pct, stall_pct;
  bit   hold_start;
  logic hold_pop;
  int   held [2];
  int   err_count, checked, pushed, reg_writes, settings_count;
  int   moves_x, moves_y, full_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic res_t step_cursor(input logic [SAMPLE_W-1:0] s);
    logic [1:0]         dir;
    logic [DELAY_W-1:0] dly;
    if (s > thr_slow_high && s < thr_fast_high) begin
      dir = DIR_POS;
      dly = dly_slow;
    end else if (s > thr_fast_high) begin
      dir = DIR_POS;
      dly = dly_fast;
    end else if (s < thr_slow_low && s > thr_fast_low) begin
      dir = DIR_NEG;
      dly = dly_slow;
    end else if (s < thr_fast_low) begin
      dir = DIR_NEG;
      dly = dly_fast;
    end else begin
      dir = DIR_STOP;
      dly = '0;
    end
    if (!axis_y) begin
      if (wait_x < dly && dly != '0) begin
        wait_x = wait_x + WAIT_W'(wait_step);
      end else begin
        wait_x = '0;
        if (dir == DIR_POS) pos_x = (pos_x == POS_W'(GRID_SIZE - 1)) ? '0 : pos_x + 1'b1;
        if (dir == DIR_NEG) pos_x = (pos_x == '0) ? POS_W'(GRID_SIZE - 1) : pos_x - 1'b1;
        if (dir != DIR_STOP) moves_x++;
      end
    end else begin
      if (wait_y < dly && dly != '0) begin
        wait_y = wait_y + WAIT_W'(wait_step);
      end else begin
        wait_y = '0;
        // The Y axis runs inverted: a high reading moves the cursor up the grid.
        if (dir == DIR_POS) pos_y = (pos_y == '0) ? POS_W'(GRID_SIZE - 1) : pos_y - 1'b1;
        if (dir == DIR_NEG) pos_y = (pos_y == POS_W'(GRID_SIZE - 1)) ? '0 : pos_y + 1'b1;
        if (dir != DIR_STOP) moves_y++;
        row_latch_q = ~(LINE_W'(1) << pos_y);
        col_latch_q = LINE_W'(1) << pos_x;
      end
    end
    axis_y = ~axis_y;
    return '{row_latch_q, col_latch_q, axis_y, pos_x, pos_y};
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic axis);
    int r, v;
    r = $urandom_range(99);
    if (r < 8) return SAMPLE_W'($urandom_range(1023));
    if (r < 18) begin
      case ($urandom_range(3))
        0: v = thr_fast_low;
        1: v = thr_slow_low;
        2: v = thr_slow_high;
        default: v = thr_fast_high;
      endcase
      v = v + $urandom_range(2) - 1;
    end else if (r < 22) begin
      v = $urandom_range(1) ? 1023 : 0;
    end else begin
      if ($urandom_range(15) == 0) held[axis] = $urandom_range(1023);
      v = held[axis] + $urandom_range(6) - 3;
    end
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return SAMPLE_W'(v);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < 40)
      $display("MISMATCH at result %0d, %s: got %0h, expected %0h", checked, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (pending_frames.size() == 0) begin
          report_mismatch("result with none outstanding", 0, 0);
        end else begin
          want = pending_frames.pop_front();
          if (out_row_drive !== want.row_drive)
            report_mismatch("row_drive", out_row_drive, want.row_drive);
          if (out_column_drive !== want.column_drive)
            report_mismatch("column_drive", out_column_drive, want.column_drive);
          if (out_next_channel !== want.next_channel)
            report_mismatch("next_channel", out_next_channel, want.next_channel);
          if (out_cursor_x !== want.cursor_x)
            report_mismatch("cursor_x", out_cursor_x, want.cursor_x);
          if (out_cursor_y !== want.cursor_y)
            report_mismatch("cursor_y", out_cursor_y, want.cursor_y);
          checked++;
        end
      end
      if (in_push && !in_full) begin
        want = step_cursor(in_adc_sample);
        pending_frames.push_back(typed_now ? typed_want : want);
        pushed++;
      end
      if (in_push && in_full) full_cycles++;
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          REG_FAST_LOW:   thr_fast_low = cfg_data;
          REG_SLOW_LOW:   thr_slow_low = cfg_data;
          REG_SLOW_HIGH:  thr_slow_high = cfg_data;
          REG_FAST_HIGH:  thr_fast_high = cfg_data;
          REG_SLOW_DELAY: dly_slow = cfg_data;
          REG_FAST_DELAY: dly_fast = cfg_data;
          REG_DELAY_STEP: wait_step = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always @(negedge clk) begin
    out_pop <= !hold_pop && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    hold_pop = 1'b0;
    wait (hold_start);
    @(posedge clk);
    hold_pop <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_pop <= 1'b0;
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("Watchdog: no handshake for %0d cycles.", WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input bit typed, input res_t want);
    while ($urandom_range(99) < send_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    typed_now = typed;
    typed_want = want;
    in_push <= 1'b1;
    in_adc_sample <= s;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] fl, sl, sh, fh, sd, fd, st);
    drain_results();
    write_reg(REG_FAST_LOW, fl);
    write_reg(REG_SLOW_LOW, sl);
    write_reg(REG_SLOW_HIGH, sh);
    write_reg(REG_FAST_HIGH, fh);
    write_reg(REG_SLOW_DELAY, sd);
    write_reg(REG_FAST_DELAY, fd);
    write_reg(REG_DELAY_STEP, st);
    if ($urandom_range(1)) write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(1023)));
    settings_count++;
  endtask

  task automatic run_phase(input int count, input int s_pct, input int r_pct);
    send_pct = s_pct;
    stall_pct = r_pct;
    repeat (count) push_sample(pick_sample(axis_y), 1'b0, '0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_adc_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_start = 1'b0;
    typed_now = 1'b0;
    typed_want = '0;
    send_pct = 0;
    stall_pct = 0;
    held[0] = 700;
    held[1] = 300;
    thr_fast_low = RST_FAST_LOW;
    thr_slow_low = RST_SLOW_LOW;
    thr_slow_high = RST_SLOW_HIGH;
    thr_fast_high = RST_FAST_HIGH;
    dly_slow = RST_SLOW_DELAY;
    dly_fast = RST_FAST_DELAY;
    wait_step = RST_DELAY_STEP;
    axis_y = 1'b0;
    pos_x = '0;
    pos_y = '0;
    wait_x = '0;
    wait_y = '0;
    row_latch_q = ROWS_OFF;
    col_latch_q = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].is_cfg) begin
        drain_results();
        write_reg(DIRECTED[i].idx, DIRECTED[i].val);
      end else begin
        push_sample(DIRECTED[i].val, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    load_settings(10'd250, 10'd500, 10'd550, 10'd787, 10'd400, 10'd200, 10'd20);
    run_phase(250, 0, 0);
    load_settings(10'd250, 10'd500, 10'd550, 10'd787, 10'd40, 10'd20, 10'd5);
    run_phase(250, 54, 0);
    load_settings(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1);
    run_phase(200, 0, 54);
    // Only the low byte of the step register is kept.
    load_settings(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'h3FF);
    run_phase(250, 6, 6);
    load_settings(10'd800, 10'd600, 10'd300, 10'd100, 10'd30, 10'd10, 10'd3);
    run_phase(200, 0, 0);
    load_settings(10'd250, 10'd500, 10'd550, 10'd787, 10'd5, 10'd3, 10'd0);
    run_phase(100, 54, 0);
    load_settings(10'd250, 10'd500, 10'd550, 10'd787, 10'd60, 10'd30, 10'd7);
    hold_start = 1'b1;
    run_phase(150, 0, 0);
    load_settings(CFG_DATA_W'($urandom_range(1023)), CFG_DATA_W'($urandom_range(1023)),
                  CFG_DATA_W'($urandom_range(1023)), CFG_DATA_W'($urandom_range(1023)),
                  CFG_DATA_W'($urandom_range(1023)), CFG_DATA_W'($urandom_range(1023)),
                  CFG_DATA_W'($urandom_range(255)));
    run_phase(200, 0, 54);
    load_settings(10'd250, 10'd500, 10'd550, 10'd787, 10'd400, 10'd200, 10'd20);
    run_phase(200, 6, 6);
    drain_results();

    repeat (10) @(negedge clk);
    if (pending_frames.size() != 0)
      report_mismatch("results never produced", 0, pending_frames.size());
    $display("Run covered %0d samples, %0d checked results, %0d settings (%0d writes).",
             pushed, checked, settings_count, reg_writes);
    $display("Predicted cursor moves: %0d on X, %0d on Y; input blocked by full on %0d cycles.",
             moves_x, moves_y, full_cycles);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
